@@ design/gap_buffer_text_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Gap buffer text engine assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef GAP_BUFFER_TEXT_ENGINE_ASSERT_SVH
`define GAP_BUFFER_TEXT_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gap buffer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define GBTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gap buffer check failed one cycle later");

`endif

@@ design/gbte_pkg.sv @@
// ----------------------------------------------------------------------------
// Gap buffer text engine package
// Shared field types, command and status codes, and the control and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gbte_pkg;

    localparam int FIELD_W = 11;
    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 2;

    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [STAT_W-1:0]  t_status;

    localparam t_cmd CMD_MOVE    = 3'd0;
    localparam t_cmd CMD_INSERT  = 3'd1;
    localparam t_cmd CMD_DELETE  = 3'd2;
    localparam t_cmd CMD_REPLACE = 3'd3;
    localparam t_cmd CMD_READ    = 3'd4;
    localparam t_cmd CMD_NEXT    = 3'd5;
    localparam t_cmd CMD_PREV    = 3'd6;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    typedef struct packed {
        t_cmd   command;
        t_byte  value;
        t_field offset;
        t_field count;
    } t_req;

    typedef struct packed {
        t_byte   byte_out;
        t_status status;
        t_field  text_length;
        t_field  caret_position;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic exec;
        logic gap_step;
        logic edit;
        logic look;
        logic emit;
    } t_dp_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic gap_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ design/gbte_stream_if.sv @@
// ----------------------------------------------------------------------------
// Gap buffer text engine stream interface
// Valid and ready handshake with a typed payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbte_stream_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/gap_buffer_text_engine.sv @@
// A text buffer of DEPTH bytes split by a gap, with a caret, that answers
// every command transaction with one result transaction carrying the byte
// at the caret, a status, the text length and the caret. Commands are taken
// one at a time. Move, replace, read, next, previous, the unused command code
// and an insert into a full buffer pass through execute, lookup and result.
// Any other insert and every delete first slide the gap to the caret through
// the text memory, one byte per cycle, before the edit, lookup and result.
// A result that is not taken holds the engine only when the next one is
// ready to leave. The text memory needs no clearing after reset.

// ----------------------------------------------------------------------------
// Gap buffer text engine
// Top level joining the controller and the datapath to the stream channels.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_buffer_text_engine #(
    parameter int DEPTH = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    gbte_stream_if.sink   i_req,
    gbte_stream_if.source o_rsp
);
    import gbte_pkg::*;

    t_dp_ctrl ctrl;
    t_dp_stat stat;

    gbte_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    gbte_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_req_data  (i_req.data),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_data  (o_rsp.data)
    );

endmodule

`default_nettype wire

@@ design/gbte_datapath.sv @@
// ----------------------------------------------------------------------------
// Gap buffer text engine datapath
// Text store, gap and caret registers, gap copy pipeline and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbte_datapath #(
    parameter int DEPTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gbte_pkg::t_dp_ctrl i_ctrl,
    output gbte_pkg::t_dp_stat     o_stat,
    input  wire gbte_pkg::t_req    i_req_data,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_ready,
    output gbte_pkg::t_rsp         o_rsp_data
);
    import gbte_pkg::*;

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = (PW > FIELD_W) ? PW : FIELD_W;
    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
    localparam logic [PW-1:0] ONE_P   = PW'(1);

    logic [BYTE_W-1:0] mem [DEPTH];

    logic [PW-1:0] r_gf, n_gf;
    logic [PW-1:0] r_gp, n_gp;
    logic [PW-1:0] r_caret, n_caret;
    t_status       r_status, n_status;
    t_cmd          r_cmd;
    t_byte         r_val;
    t_field        r_off;
    t_field        r_cnt;
    logic          r_wr_pend;
    logic [AW-1:0] r_wr_addr;
    t_byte         r_rd_data;
    logic          r_out_valid;
    t_rsp          r_out;

    logic [PW-1:0] gap_len;
    logic [PW-1:0] text_len;
    logic [PW-1:0] phys;
    logic [PW-1:0] rem;
    logic [PW-1:0] cnt_eff;
    logic          at_end;
    logic          go_left;
    logic          step;
    logic [PW-1:0] src_addr;
    logic [PW-1:0] dst_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_byte         wr_data;

    assign gap_len  = r_gp - r_gf;
    assign text_len = DEPTH_P - gap_len;
    assign at_end   = (r_caret >= text_len);
    assign phys     = (r_caret < r_gf) ? r_caret : (r_caret + gap_len);
    assign go_left  = (r_caret < r_gf);
    assign step     = i_ctrl.gap_step && (r_caret != r_gf);
    assign src_addr = go_left ? (r_gf - ONE_P) : r_gp;
    assign dst_addr = go_left ? (r_gp - ONE_P) : r_gf;
    assign rem      = text_len - r_caret;
    assign cnt_eff  = (CW'(r_cnt) > CW'(rem)) ? rem : PW'(r_cnt);

    assign rd_en   = step || i_ctrl.look;
    assign rd_addr = step ? AW'(src_addr) : AW'(phys);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wr_addr;
        wr_data = r_rd_data;
        if (r_wr_pend) begin
            wr_en = 1'b1;
        end else if (i_ctrl.exec && (r_cmd == CMD_REPLACE) && !at_end) begin
            wr_en   = 1'b1;
            wr_addr = AW'(phys);
            wr_data = r_val;
        end else if (i_ctrl.edit && (r_cmd == CMD_INSERT)) begin
            wr_en   = 1'b1;
            wr_addr = AW'(r_gf);
            wr_data = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        n_gf     = r_gf;
        n_gp     = r_gp;
        n_caret  = r_caret;
        n_status = r_status;
        if (i_ctrl.load) begin
            n_status = ST_OK;
        end else if (i_ctrl.exec) begin
            case (r_cmd)
                CMD_MOVE: begin
                    if (CW'(r_off) > CW'(text_len)) begin
                        n_caret  = text_len;
                        n_status = ST_RANGE;
                    end else begin
                        n_caret = PW'(r_off);
                    end
                end
                CMD_INSERT: begin
                    if (text_len == DEPTH_P) begin
                        n_status = ST_FULL;
                    end
                end
                CMD_DELETE, CMD_READ: begin
                    n_status = ST_OK;
                end
                CMD_REPLACE: begin
                    if (at_end) begin
                        n_status = ST_RANGE;
                    end
                end
                CMD_NEXT: begin
                    if (at_end) begin
                        n_status = ST_RANGE;
                    end else begin
                        n_caret = r_caret + ONE_P;
                    end
                end
                CMD_PREV: begin
                    if (r_caret == '0) begin
                        n_status = ST_RANGE;
                    end else begin
                        n_caret = r_caret - ONE_P;
                    end
                end
                default: begin
                    n_status = ST_RANGE;
                end
            endcase
        end else if (step) begin
            if (go_left) begin
                n_gf = r_gf - ONE_P;
                n_gp = r_gp - ONE_P;
            end else begin
                n_gf = r_gf + ONE_P;
                n_gp = r_gp + ONE_P;
            end
        end else if (i_ctrl.edit) begin
            if (r_cmd == CMD_INSERT) begin
                n_gf    = r_gf + ONE_P;
                n_caret = r_caret + ONE_P;
            end else begin
                n_gp = r_gp + cnt_eff;
                if (CW'(r_cnt) > CW'(rem)) begin
                    n_status = ST_RANGE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gf        <= '0;
            r_gp        <= DEPTH_P;
            r_caret     <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_gf      <= n_gf;
            r_gp      <= n_gp;
            r_caret   <= n_caret;
            r_status  <= n_status;
            r_wr_pend <= step;
            if (i_ctrl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_req_data.command;
            r_val <= i_req_data.value;
            r_off <= i_req_data.offset;
            r_cnt <= i_req_data.count;
        end
        if (step) begin
            r_wr_addr <= AW'(dst_addr);
        end
        if (i_ctrl.emit) begin
            r_out.byte_out       <= at_end ? '0 : r_rd_data;
            r_out.status         <= r_status;
            r_out.text_length    <= t_field'(text_len);
            r_out.caret_position <= t_field'(r_caret);
        end
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.full     = (text_len == DEPTH_P);
    assign o_stat.gap_done = (r_caret == r_gf);
    assign o_stat.out_free = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid     = r_out_valid;
    assign o_rsp_data      = r_out;

endmodule

`default_nettype wire

@@ design/gbte_controller.sv @@
// ----------------------------------------------------------------------------
// Gap buffer text engine controller
// Sequences commands: execute, gap copy and edit for edits, lookup, result.
// ----------------------------------------------------------------------------
`default_nettype none

module gbte_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    output logic                    o_req_ready,
    input  wire gbte_pkg::t_dp_stat i_stat,
    output gbte_pkg::t_dp_ctrl      o_ctrl
);
    import gbte_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_GAP  = 3'd2;
    localparam logic [2:0] S_EDIT = 3'd3;
    localparam logic [2:0] S_LOOK = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctrl.exec = 1'b1;
                if ((i_stat.cmd == CMD_INSERT && !i_stat.full) ||
                    i_stat.cmd == CMD_DELETE) begin
                    n_state = S_GAP;
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_GAP: begin
                o_ctrl.gap_step = 1'b1;
                if (i_stat.gap_done) begin
                    n_state = S_EDIT;
                end
            end
            S_EDIT: begin
                o_ctrl.edit = 1'b1;
                n_state     = S_LOOK;
            end
            S_LOOK: begin
                o_ctrl.look = 1'b1;
                n_state     = S_RES;
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_ctrl.emit = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

@@ design/gbte_checker.sv @@
// ----------------------------------------------------------------------------
// Gap buffer text engine checker
// Port-level checks on command and result transactions, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gap_buffer_text_engine_assert.svh"

module gbte_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_req_valid,
    input wire logic           i_req_ready,
    input wire logic           i_rsp_valid,
    input wire logic           i_rsp_ready,
    input wire gbte_pkg::t_rsp i_rsp_data
);
    import gbte_pkg::*;

    `GBTE_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)
    `GBTE_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_data))
    `GBTE_ASSERT_NOW(a_caret_in_text, i_clk, i_rst_n, i_rsp_valid, i_rsp_data.caret_position <= i_rsp_data.text_length)
    `GBTE_ASSERT_NOW(a_zero_at_end, i_clk, i_rst_n, i_rsp_valid && (i_rsp_data.caret_position == i_rsp_data.text_length), i_rsp_data.byte_out == '0)
    `GBTE_ASSERT_NOW(a_status_code, i_clk, i_rst_n, i_rsp_valid, i_rsp_data.status == ST_OK || i_rsp_data.status == ST_FULL || i_rsp_data.status == ST_RANGE)

endmodule

bind gap_buffer_text_engine gbte_checker u_gbte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire

@@ bench/gbte_edit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap buffer text engine edit checker
// Watches the command and result channels, keeps its own copy of the text,
// the gap and the caret, works out the result of every accepted command
// transaction and compares each result transaction with the oldest one due.
// ----------------------------------------------------------------------------

module gbte_edit_checker
    import gbte_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gbte_stream_if    i_req,
    gbte_stream_if    i_rsp,
    output int        o_fail_count,
    output int        o_pending
);

    t_byte  text_mem [DEPTH];
    t_field gap_lo;
    t_field gap_hi;
    t_field caret;
    t_rsp   due_reports [$];
    int     mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic int unsigned gap_span();
        return int'(gap_hi) - int'(gap_lo);
    endfunction

    function automatic int unsigned text_len();
        return DEPTH - gap_span();
    endfunction

    function automatic int unsigned cell_of(int unsigned pos);
        return (pos < gap_lo) ? pos : pos + gap_span();
    endfunction

    function automatic t_byte byte_under_caret();
        if (caret >= text_len()) begin
            return '0;
        end
        return text_mem[cell_of(caret)];
    endfunction

    // Slides the gap so that it starts at the caret, one byte at a time.
    function automatic void slide_gap_to_caret();
        int unsigned span;
        int unsigned i;
        span = gap_span();
        if (caret < gap_lo) begin
            for (i = gap_lo; i > caret; i--) begin
                text_mem[i - 1 + span] = text_mem[i - 1];
            end
            gap_lo = caret;
            gap_hi = t_field'(caret + span);
        end else if (caret > gap_lo) begin
            for (i = 0; i < caret - gap_lo; i++) begin
                text_mem[gap_lo + i] = text_mem[gap_hi + i];
            end
            gap_hi = t_field'(gap_hi + (caret - gap_lo));
            gap_lo = caret;
        end
    endfunction

    function automatic t_rsp apply_edit(t_req cmd);
        t_rsp        rep;
        int unsigned len;
        int unsigned cnt;
        int unsigned off;
        rep        = '0;
        rep.status = ST_OK;
        len        = text_len();
        off        = cmd.offset;
        cnt        = cmd.count;
        case (cmd.command)
            CMD_MOVE: begin
                if (off > len) begin
                    off        = len;
                    rep.status = ST_RANGE;
                end
                caret = t_field'(off);
            end
            CMD_INSERT: begin
                if (len >= DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    slide_gap_to_caret();
                    text_mem[gap_lo] = cmd.value;
                    gap_lo++;
                    caret++;
                end
            end
            CMD_DELETE: begin
                slide_gap_to_caret();
                if (cnt > len - caret) begin
                    cnt        = len - caret;
                    rep.status = ST_RANGE;
                end
                gap_hi = t_field'(gap_hi + cnt);
            end
            CMD_REPLACE: begin
                if (caret >= len) begin
                    rep.status = ST_RANGE;
                end else begin
                    text_mem[cell_of(caret)] = cmd.value;
                end
            end
            CMD_READ: begin
            end
            CMD_NEXT: begin
                if (caret >= len) begin
                    rep.status = ST_RANGE;
                end else begin
                    caret++;
                end
            end
            CMD_PREV: begin
                if (caret == 0) begin
                    rep.status = ST_RANGE;
                end else begin
                    caret--;
                end
            end
            default: begin
                rep.status = ST_RANGE;
            end
        endcase
        rep.byte_out       = byte_under_caret();
        rep.text_length    = t_field'(text_len());
        rep.caret_position = caret;
        return rep;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rsp got;
        t_rsp want;
        t_req cmd;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                text_mem[i] = '0;
            end
            gap_lo = '0;
            gap_hi = t_field'(DEPTH);
            caret  = '0;
            due_reports.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.data;
                if (due_reports.size() == 0) begin
                    $error("result transaction with no command waiting for it");
                    mismatches++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("byte_out", want.byte_out, got.byte_out);
                    check_field("status", want.status, got.status);
                    check_field("text_length", want.text_length, got.text_length);
                    check_field("caret_position", want.caret_position,
                                got.caret_position);
                end
            end
            if (i_req.valid && i_req.ready) begin
                cmd = i_req.data;
                due_reports.push_back(apply_edit(cmd));
            end
        end
        o_pending <= due_reports.size();
    end

endmodule

@@ bench/tb_gap_buffer_text_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap buffer text engine testbench
// Drives directed edits, a long run of random typing, cutting and caret
// walks, then a short closing sequence at the text ends, with random idling
// on both channels and one long result stall; the edit checker judges every
// result.
// ----------------------------------------------------------------------------

module tb_gap_buffer_text_engine;
    import gbte_pkg::*;

    localparam int     DEPTH        = 1024;
    localparam int     ITEM_TARGET  = 580;
    localparam int     TAIL_ITEMS   = 13;
    localparam int     IDLE_PERCENT = 27;
    localparam int     CALM_FIRST   = 300;
    localparam int     CALM_LAST    = 420;
    localparam int     STALL_AFTER  = 60;
    localparam int     STALL_CYCLES = 400;
    localparam longint CYCLE_LIMIT  = 6_000_000;
    localparam t_cmd   CMD_UNUSED   = 3'd7;

    logic   clk = 1'b0;
    logic   rst_n;
    int     mismatches;
    int     in_flight;
    int     issued = 0;
    longint cycles = 0;

    gbte_stream_if #(.T_DATA(t_req)) cmd_if ();
    gbte_stream_if #(.T_DATA(t_rsp)) rsp_if ();

    gap_buffer_text_engine #(.DEPTH(DEPTH)) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (cmd_if),
        .o_rsp   (rsp_if)
    );

    gbte_edit_checker #(.DEPTH(DEPTH)) edit_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (cmd_if),
        .i_rsp        (rsp_if),
        .o_fail_count (mismatches),
        .o_pending    (in_flight)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_byte rand_byte();
        return t_byte'($urandom);
    endfunction

    function automatic t_field rand_field();
        return t_field'($urandom);
    endfunction

    function automatic t_field pick_offset();
        if ($urandom_range(0, 99) < 85) begin
            return t_field'($urandom_range(0, 700));
        end
        return rand_field();
    endfunction

    function automatic t_field pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            return t_field'($urandom_range(0, 6));
        end else if (roll < 95) begin
            return t_field'($urandom_range(0, 64));
        end
        return rand_field();
    endfunction

    task automatic send_cmd(input t_cmd op, input t_byte val, input t_field off,
                            input t_field cnt);
        t_req item;
        item.command = op;
        item.value   = val;
        item.offset  = off;
        item.count   = cnt;
        while (!(issued >= CALM_FIRST && issued < CALM_LAST)
               && $urandom_range(0, 99) < IDLE_PERCENT) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= item;
        @(posedge clk);
        while (!cmd_if.ready) begin
            @(posedge clk);
        end
        issued++;
    endtask

    task automatic send_walk_step();
        case ($urandom_range(0, 3))
            0: send_cmd(CMD_NEXT, rand_byte(), rand_field(), rand_field());
            1: send_cmd(CMD_PREV, rand_byte(), rand_field(), rand_field());
            2: send_cmd(CMD_READ, rand_byte(), rand_field(), rand_field());
            default: send_cmd(CMD_REPLACE, rand_byte(), rand_field(), rand_field());
        endcase
    endtask

    // The result side idles at random, holds off once for a long stretch and
    // keeps one stretch free of idling.
    initial begin : result_sink
        int drained;
        bit stalled;
        drained = 0;
        stalled = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready) begin
                drained++;
            end
            if (drained == STALL_AFTER && !stalled) begin
                stalled = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            rsp_if.ready <= (drained >= CALM_FIRST && drained < CALM_LAST)
                            || $urandom_range(0, 99) >= IDLE_PERCENT;
        end
    end

    initial begin : stimulus
        int roll;
        rst_n        <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_cmd(CMD_READ,    8'h00, 11'd0,    11'd0);
        send_cmd(CMD_PREV,    8'h00, 11'd0,    11'd0);
        send_cmd(CMD_NEXT,    8'h00, 11'd0,    11'd0);
        send_cmd(CMD_REPLACE, 8'hFF, 11'd0,    11'd0);
        send_cmd(CMD_DELETE,  8'h00, 11'd0,    11'd5);
        send_cmd(CMD_MOVE,    8'h00, 11'h7FF,  11'h7FF);
        send_cmd(CMD_INSERT,  8'h00, 11'd0,    11'd0);
        send_cmd(CMD_INSERT,  8'hFF, 11'h7FF,  11'h7FF);
        send_cmd(CMD_INSERT,  8'hA5, 11'd0,    11'd0);
        send_cmd(CMD_INSERT,  8'h5A, 11'd0,    11'd0);
        send_cmd(CMD_MOVE,    8'h00, 11'd0,    11'd0);
        send_cmd(CMD_READ,    8'h00, 11'd0,    11'd0);
        send_cmd(CMD_NEXT,    8'h00, 11'd0,    11'd0);
        send_cmd(CMD_REPLACE, 8'h3C, 11'd0,    11'd0);
        send_cmd(CMD_PREV,    8'h00, 11'd0,    11'd0);
        send_cmd(CMD_INSERT,  8'h11, 11'd0,    11'd0);
        send_cmd(CMD_MOVE,    8'h00, 11'd1024, 11'd0);
        send_cmd(CMD_MOVE,    8'h00, 11'd5,    11'd0);
        send_cmd(CMD_PREV,    8'h00, 11'd0,    11'd0);
        send_cmd(CMD_DELETE,  8'h00, 11'd0,    11'd0);
        send_cmd(CMD_DELETE,  8'h00, 11'd0,    11'h7FF);
        send_cmd(CMD_UNUSED,  8'hFF, 11'h7FF,  11'h7FF);
        send_cmd(CMD_MOVE,    8'h00, 11'd2,    11'd0);
        send_cmd(CMD_DELETE,  8'h00, 11'd0,    11'd1);

        while (issued < ITEM_TARGET - TAIL_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                send_cmd(CMD_MOVE, rand_byte(), pick_offset(), rand_field());
                repeat ($urandom_range(1, 8)) begin
                    send_cmd(CMD_INSERT, rand_byte(), rand_field(), rand_field());
                end
            end else if (roll < 55) begin
                send_cmd(CMD_MOVE, rand_byte(), pick_offset(), rand_field());
                send_cmd(CMD_DELETE, rand_byte(), rand_field(), pick_count());
            end else if (roll < 75) begin
                repeat ($urandom_range(1, 6)) begin
                    send_walk_step();
                end
            end else begin
                send_cmd(t_cmd'($urandom_range(0, 7)), rand_byte(), rand_field(),
                         rand_field());
            end
        end

        send_cmd(CMD_MOVE,    rand_byte(), 11'h7FF, rand_field());
        send_cmd(CMD_NEXT,    rand_byte(), rand_field(), rand_field());
        send_cmd(CMD_REPLACE, rand_byte(), rand_field(), rand_field());
        send_cmd(CMD_MOVE,    rand_byte(), 11'd0, rand_field());
        send_cmd(CMD_REPLACE, rand_byte(), rand_field(), rand_field());
        send_cmd(CMD_READ,    rand_byte(), rand_field(), rand_field());
        send_cmd(CMD_MOVE,    rand_byte(), pick_offset(), rand_field());
        send_cmd(CMD_DELETE,  rand_byte(), rand_field(), 11'd1);
        send_cmd(CMD_INSERT,  rand_byte(), rand_field(), rand_field());
        send_cmd(CMD_INSERT,  rand_byte(), rand_field(), rand_field());
        send_cmd(CMD_MOVE,    rand_byte(), 11'd0, rand_field());
        send_cmd(CMD_DELETE,  rand_byte(), rand_field(), 11'h7FF);
        send_cmd(CMD_READ,    rand_byte(), rand_field(), rand_field());

        cmd_if.valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (in_flight != 0);
        repeat (DEPTH + 16) @(posedge clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/gbte_pkg.sv
design/gbte_stream_if.sv
design/gbte_datapath.sv
design/gbte_controller.sv
design/gap_buffer_text_engine.sv
design/gbte_checker.sv
bench/gbte_edit_checker.sv
bench/tb_gap_buffer_text_engine.sv
